>>> design/vtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types, constants and helpers of the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtp_pkg;

   // Field and datapath widths
   localparam int COORD_W  = 16;              // Q3.12 vertex, Q4.11 entry, outputs
   localparam int PROD_W   = 32;              // entry * coordinate
   localparam int CLIP_W   = 34;              // sum of four products
   localparam int NUM_W    = 48;              // scaled numerator
   localparam int Q_BITS   = 17;              // quotient bits kept before saturation
   localparam int REM_W    = CLIP_W + Q_BITS; // divider remainder
   localparam int SUM_W    = 20;              // viewport offset plus quotient
   localparam int HALF_W   = 12;              // holds the largest half extent
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = 3;
   localparam int DATA_W   = 32;
   localparam int W_SHIFT  = 12;              // w = 1.0 in Q3.12
   localparam int Z_SHIFT  = 14;              // depth scale, Q1.14

   localparam int HALF_WIDTH_DEF  = 160;
   localparam int HALF_HEIGHT_DEF = 100;

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_ROW0_LO = 3'd0,
      REG_ROW0_HI = 3'd1,
      REG_ROW1_LO = 3'd2,
      REG_ROW1_HI = 3'd3,
      REG_ROW2_LO = 3'd4,
      REG_ROW2_HI = 3'd5,
      REG_ROW3_LO = 3'd6,
      REG_ROW3_HI = 3'd7
   } reg_idx_type;

   // Identity matrix after reset
   localparam logic [DATA_W-1:0] RST_DIAG_LO = 32'h0000_0800;
   localparam logic [DATA_W-1:0] RST_DIAG_HI = 32'h0800_0000;

   typedef logic [NUM_REGS-1:0][DATA_W-1:0] matrix_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
      logic signed [COORD_W-1:0] depth;
      logic                      w_zero;
      logic                      clamped;
   } rsp_payload_type;

   // One division lane: remainder, quotient so far, sign and overflow
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [Q_BITS-1:0] quot;
      logic              neg;
      logic              ovf;
   } lane_type;

   // Lanes: 2 = x, 1 = y, 0 = depth
   typedef struct packed {
      lane_type [2:0]    lane;
      logic [CLIP_W-1:0] den;
      logic              w_zero;
   } div_stage_type;

   // One restoring division step on every lane for quotient bit pos
   function automatic div_stage_type div_step(input div_stage_type s, input int pos);
      div_stage_type    r;
      logic [REM_W-1:0] trial;
      r     = s;
      trial = REM_W'(s.den) << pos;
      for (int l = 0; l < 3; l++) begin
         if (s.lane[l].rem >= trial) begin
            r.lane[l].rem       = s.lane[l].rem - trial;
            r.lane[l].quot[pos] = 1'b1;
         end
      end
      return r;
   endfunction

   // Saturate to 16 bits; top bit of the result is the clamp flag
   function automatic logic [COORD_W:0] sat16(input logic signed [SUM_W-1:0] v);
      logic [COORD_W:0] r;
      if (v > SUM_W'(32767))       r = {1'b1, 16'h7FFF};
      else if (v < -SUM_W'(32768)) r = {1'b1, 16'h8000};
      else                         r = {1'b0, v[COORD_W-1:0]};
      return r;
   endfunction

endpackage

>>> design/vtp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_csr
// Matrix register file, written through the plain CSR write port.
// ----------------------------------------------------------------------------
module vtp_csr import vtp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_idx,
   input  logic [DATA_W-1:0] csr_wdata,
   output matrix_type        matrix
);

   // Identity matrix, register 7 first
   localparam matrix_type RST_MATRIX = {RST_DIAG_HI, 32'h0, RST_DIAG_LO, 32'h0,
                                        32'h0, RST_DIAG_HI, 32'h0, RST_DIAG_LO};

   matrix_type regs_ff, regs_in;

   // Next register contents
   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (reg_idx_type'(csr_idx))
            REG_ROW0_LO: regs_in[REG_ROW0_LO] = csr_wdata;
            REG_ROW0_HI: regs_in[REG_ROW0_HI] = csr_wdata;
            REG_ROW1_LO: regs_in[REG_ROW1_LO] = csr_wdata;
            REG_ROW1_HI: regs_in[REG_ROW1_HI] = csr_wdata;
            REG_ROW2_LO: regs_in[REG_ROW2_LO] = csr_wdata;
            REG_ROW2_HI: regs_in[REG_ROW2_HI] = csr_wdata;
            REG_ROW3_LO: regs_in[REG_ROW3_LO] = csr_wdata;
            REG_ROW3_HI: regs_in[REG_ROW3_HI] = csr_wdata;
            default:     regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= RST_MATRIX;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign matrix = regs_ff;

endmodule

>>> design/vtp_mvp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_mvp
// Matrix multiply and divider setup: products, clip sums, scaled
// numerators, magnitudes and the quotient range check, one stage each.
// ----------------------------------------------------------------------------
module vtp_mvp import vtp_pkg::*; #(
   parameter int HALF_WIDTH  = HALF_WIDTH_DEF,
   parameter int HALF_HEIGHT = HALF_HEIGHT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  matrix_type      matrix,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output div_stage_type   out_data
);

   localparam logic signed [NUM_W-1:0] HW_S = NUM_W'(HALF_WIDTH);
   localparam logic signed [NUM_W-1:0] HH_S = NUM_W'(HALF_HEIGHT);

   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   logic signed [CLIP_W-1:0] clip_ff [4];
   logic signed [CLIP_W-1:0] clip_in [4];
   logic signed [NUM_W-1:0]  num_ff  [3];
   logic signed [NUM_W-1:0]  num_in  [3];
   logic signed [CLIP_W-1:0] den_ff, den_in;
   div_stage_type            mag_ff, mag_in, chk_ff, chk_in;
   logic [4:0]               vld_ff;
   logic [4:0]               adv;

   function automatic logic signed [COORD_W-1:0] entry(input matrix_type m,
                                                       input int r, input int c);
      logic [DATA_W-1:0] w;
      w = m[r*2 + c/2];
      return (c % 2 == 1) ? w[DATA_W-1:COORD_W] : w[COORD_W-1:0];
   endfunction

   // Stall chain: a stage moves when it is empty or its successor moves
   always_comb begin
      adv[4] = !vld_ff[4] || out_ready;
      for (int k = 3; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   // Stage 1: sixteen products, w column is a shift
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_in[r][0] = entry(matrix, r, 0) * in_data.vertex_x;
         prod_in[r][1] = entry(matrix, r, 1) * in_data.vertex_y;
         prod_in[r][2] = entry(matrix, r, 2) * in_data.vertex_z;
         prod_in[r][3] = PROD_W'(entry(matrix, r, 3)) <<< W_SHIFT;
      end
   end

   // Stage 2: clip coordinates
   always_comb begin
      for (int r = 0; r < 4; r++)
         clip_in[r] = CLIP_W'(prod_ff[r][0]) + CLIP_W'(prod_ff[r][1])
                    + CLIP_W'(prod_ff[r][2]) + CLIP_W'(prod_ff[r][3]);
   end

   // Stage 3: scaled numerators
   always_comb begin
      num_in[2] = NUM_W'(clip_ff[0]) * HW_S;
      num_in[1] = NUM_W'(clip_ff[1]) * HH_S;
      num_in[0] = NUM_W'(clip_ff[2]) <<< Z_SHIFT;
      den_in    = clip_ff[3];
   end

   // Stage 4: magnitudes and quotient signs
   always_comb begin
      mag_in        = '0;
      mag_in.den    = den_ff[CLIP_W-1] ? CLIP_W'(-den_ff) : CLIP_W'(den_ff);
      mag_in.w_zero = (den_ff == '0);
      for (int l = 0; l < 3; l++) begin
         mag_in.lane[l].rem = REM_W'(num_ff[l][NUM_W-1] ? NUM_W'(-num_ff[l])
                                                         : NUM_W'(num_ff[l]));
         mag_in.lane[l].neg = num_ff[l][NUM_W-1] ^ den_ff[CLIP_W-1];
      end
   end

   // Stage 5: quotient too large for the kept bits saturates
   always_comb begin
      chk_in = mag_ff;
      for (int l = 0; l < 3; l++)
         chk_in.lane[l].ovf = mag_ff.lane[l].rem >= (REM_W'(mag_ff.den) << Q_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < 5; k++)
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) prod_ff <= prod_in;
      if (adv[1] && vld_ff[0]) clip_ff <= clip_in;
      if (adv[2] && vld_ff[1]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (adv[3] && vld_ff[2]) mag_ff <= mag_in;
      if (adv[4] && vld_ff[3]) chk_ff <= chk_in;
   end

   assign out_valid = vld_ff[4];
   assign out_data  = chk_ff;

endmodule

>>> design/vtp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_div
// Pipelined restoring divider, one quotient bit per stage on three lanes
// that share the clip w divisor.
// ----------------------------------------------------------------------------
module vtp_div import vtp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  div_stage_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output div_stage_type out_data
);

   div_stage_type     stage_ff [Q_BITS];
   div_stage_type     stage_in [Q_BITS];
   logic [Q_BITS-1:0] vld_ff;
   logic [Q_BITS:0]   adv;

   // Stall chain
   always_comb begin
      adv[Q_BITS] = out_ready;
      for (int k = Q_BITS-1; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   // Stage k resolves quotient bit Q_BITS-1-k
   always_comb begin
      stage_in[0] = div_step(in_data, Q_BITS-1);
      for (int k = 1; k < Q_BITS; k++) stage_in[k] = div_step(stage_ff[k-1], Q_BITS-1-k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < Q_BITS; k++)
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && in_valid) stage_ff[0] <= stage_in[0];
      for (int k = 1; k < Q_BITS; k++)
         if (adv[k] && vld_ff[k-1]) stage_ff[k] <= stage_in[k];
   end

   assign out_valid = vld_ff[Q_BITS-1];
   assign out_data  = stage_ff[Q_BITS-1];

`ifndef SYNTHESIS
   // A finished x or depth lane in range leaves a remainder below the divisor
   a_rem_x: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.w_zero && !out_data.lane[2].ovf
      |-> out_data.lane[2].rem < REM_W'(out_data.den))
      else $error("x remainder not below divisor");
   a_rem_z: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.w_zero && !out_data.lane[0].ovf
      |-> out_data.lane[0].rem < REM_W'(out_data.den))
      else $error("depth remainder not below divisor");
`endif

endmodule

>>> design/vtp_vport.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_vport
// Viewport mapping: signed quotients, screen offsets, saturation and the
// output register.
// ----------------------------------------------------------------------------
module vtp_vport import vtp_pkg::*; #(
   parameter int HALF_WIDTH  = HALF_WIDTH_DEF,
   parameter int HALF_HEIGHT = HALF_HEIGHT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  div_stage_type   in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   localparam logic signed [SUM_W-1:0] HW_S = SUM_W'(HALF_WIDTH);
   localparam logic signed [SUM_W-1:0] HH_S = SUM_W'(HALF_HEIGHT);

   logic signed [SUM_W-1:0] q [3];
   logic [COORD_W:0]        sx, sy, sz;
   rsp_payload_type         out_ff, out_in;
   logic                    vld_ff;

   assign in_ready = !vld_ff || out_ready;

   // Signed quotients and viewport offsets
   always_comb begin
      for (int l = 0; l < 3; l++)
         q[l] = in_data.lane[l].neg ? -SUM_W'(in_data.lane[l].quot)
                                    : SUM_W'(in_data.lane[l].quot);
      sx = in_data.lane[2].ovf ? (in_data.lane[2].neg ? {1'b1, 16'h8000} : {1'b1, 16'h7FFF})
                               : sat16(HW_S + q[2]);
      sy = in_data.lane[1].ovf ? (in_data.lane[1].neg ? {1'b1, 16'h7FFF} : {1'b1, 16'h8000})
                               : sat16(HH_S - q[1]);
      sz = in_data.lane[0].ovf ? (in_data.lane[0].neg ? {1'b1, 16'h8000} : {1'b1, 16'h7FFF})
                               : sat16(q[0]);
      if (in_data.w_zero) begin
         out_in        = '0;
         out_in.w_zero = 1'b1;
      end else begin
         out_in.screen_x = sx[COORD_W-1:0];
         out_in.screen_y = sy[COORD_W-1:0];
         out_in.depth    = sz[COORD_W-1:0];
         out_in.w_zero   = 1'b0;
         out_in.clamped  = sx[COORD_W] | sy[COORD_W] | sz[COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) out_ff <= out_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = out_ff;

`ifndef SYNTHESIS
   // Zero w forces every field to zero and no clamp
   a_wzero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.w_zero |-> out_data.screen_x == '0 &&
      out_data.screen_y == '0 && out_data.depth == '0 && !out_data.clamped)
      else $error("w_zero result carries data");
   // A zero-w transaction taken in shows up at the output next cycle
   a_wzero_pass: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && in_data.w_zero |=> out_valid && out_data.w_zero)
      else $error("w_zero lost in output stage");
`endif

endmodule

>>> design/vertex_transform_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_project
// Vertex transform, perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
// Accepts one vertex per clock while the output is not stalled and returns
// one screen-space transaction per vertex, in order, through 5 stages of
// matrix multiply and divider setup, 17 stages of the pipelined divider
// (one quotient bit per stage) and one output register.
// Back-pressure stalls only the stages that hold data. The matrix registers
// may only be written while no transaction is in flight.
module vertex_transform_project import vtp_pkg::*; #(
   parameter int HALF_WIDTH  = HALF_WIDTH_DEF,
   parameter int HALF_HEIGHT = HALF_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_idx,
   input  logic [DATA_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload
);

   matrix_type    matrix;
   logic          setup_valid, setup_ready, quot_valid, quot_ready;
   div_stage_type setup_data, quot_data;

   vtp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .matrix    (matrix)
   );

   vtp_mvp #(
      .HALF_WIDTH  (HALF_WIDTH),
      .HALF_HEIGHT (HALF_HEIGHT)
   ) u_mvp (
      .clock     (clock),
      .reset     (reset),
      .matrix    (matrix),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (setup_valid),
      .out_ready (setup_ready),
      .out_data  (setup_data)
   );

   vtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_ready  (setup_ready),
      .in_data   (setup_data),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_data)
   );

   vtp_vport #(
      .HALF_WIDTH  (HALF_WIDTH),
      .HALF_HEIGHT (HALF_HEIGHT)
   ) u_vport (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quot_valid),
      .in_ready  (quot_ready),
      .in_data   (quot_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

endmodule

>>> verif/tb_vertex_transform_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_project
// Self-checking bench for the vertex transform and projection pipeline.
// ----------------------------------------------------------------------------
// Directed vertices cover the identity matrix, field extremes, zero w and
// saturation. Random vertices then run under several matrices, including
// the extremes, and under several idling mixes. Each result is compared with
// its table entry or a projection computed here from the current matrix.
// ----------------------------------------------------------------------------
module tb_vertex_transform_project;
   import vtp_pkg::*;

   localparam int RAND_ITEMS = 1200;
   localparam int WATCHDOG   = 20000;
   localparam int DRAIN      = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [IDX_W-1:0]  csr_idx = '0;
   logic [DATA_W-1:0] csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_payload_type   req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_payload;

   // Matrix copy and expected screen transactions
   logic [DATA_W-1:0] mtx [NUM_REGS];
   rsp_payload_type   screen_q [$];
   int                fail_cnt = 0;
   int                idle_cnt = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                hold_rsp = 1'b0;

   // Directed table: typed expectation only where it is obvious
   typedef struct {
      logic [15:0]     x, y, z;
      bit              has_exp;
      rsp_payload_type exp_rsp;
   } vec_row_type;

   vertex_transform_project i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic signed [63:0] mtx_entry(int r, int c);
      logic [DATA_W-1:0] w;
      w = mtx[r * 2 + c / 2];
      return (c % 2) ? 64'(signed'(w[31:16])) : 64'(signed'(w[15:0]));
   endfunction

   function automatic logic signed [15:0] clip16(logic signed [63:0] v, ref bit flag);
      if (v > 32767) begin
         flag = 1'b1;
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         flag = 1'b1;
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   // Projection of one vertex with the current matrix
   function automatic rsp_payload_type project_vertex(req_payload_type p);
      logic signed [63:0] v [4];
      logic signed [63:0] cl [4];
      rsp_payload_type    r;
      bit                 flag;
      v[0] = 64'(p.vertex_x);
      v[1] = 64'(p.vertex_y);
      v[2] = 64'(p.vertex_z);
      v[3] = 64'sd4096;
      for (int i = 0; i < 4; i++) begin
         cl[i] = 0;
         for (int c = 0; c < 4; c++) cl[i] += mtx_entry(i, c) * v[c];
      end
      r = '0;
      flag = 1'b0;
      if (cl[3] == 0) begin
         r.w_zero = 1'b1;
         return r;
      end
      r.screen_x = clip16(64'sd160 + (64'sd160 * cl[0]) / cl[3], flag);
      r.screen_y = clip16(64'sd100 - (64'sd100 * cl[1]) / cl[3], flag);
      r.depth    = clip16((64'sd16384 * cl[2]) / cl[3], flag);
      r.clamped  = flag;
      return r;
   endfunction

   // One register write, then a pause with the write enable low
   task automatic write_reg(reg_idx_type idx, logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      mtx[idx] = val;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (screen_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Offer one vertex and hold it until accepted
   task automatic send_vertex(req_payload_type p, bit has_exp, rsp_payload_type e);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      screen_q.push_back(has_exp ? e : project_vertex(p));
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(2047)) - 16'd1024;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_vertices(int n);
      req_payload_type p;
      for (int i = 0; i < n; i++) begin
         p.vertex_x = rand_coord();
         p.vertex_y = rand_coord();
         p.vertex_z = rand_coord();
         send_vertex(p, 1'b0, '0);
      end
   endtask

   function automatic logic [15:0] rand_entry();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom_range(8191)) - 16'd4096;
      endcase
   endfunction

   task automatic load_matrix(int kind);
      for (int i = 0; i < NUM_REGS; i++) begin
         case (kind)
            0: write_reg(reg_idx_type'(i), 32'hFFFF_FFFF);
            1: write_reg(reg_idx_type'(i), 32'h7FFF_7FFF);
            2: write_reg(reg_idx_type'(i), 32'h8000_8000);
            default: write_reg(reg_idx_type'(i), {rand_entry(), rand_entry()});
         endcase
      end
      // keep w mostly nonzero and sensible on random matrices
      if (kind > 2 && $urandom_range(3) != 0)
         write_reg(REG_ROW3_HI, {16'($urandom_range(4095)) + 16'd64, rand_entry()});
   endtask

   // Result receiver and checker
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (screen_q.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_payload);
               fail_cnt++;
            end else begin
               e = screen_q.pop_front();
               if (rsp_payload.screen_x !== e.screen_x || rsp_payload.screen_y !== e.screen_y
                   || rsp_payload.depth !== e.depth || rsp_payload.w_zero !== e.w_zero
                   || rsp_payload.clamped !== e.clamped) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, rsp_payload);
                  fail_cnt++;
               end
            end
         end
         rsp_ready <= !hold_rsp && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted transaction or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
         $display("vertex_transform_project test failed");
         $finish;
      end
   end

   initial begin
      vec_row_type     dir_tab [$];
      req_payload_type p;
      dir_tab = '{
         '{16'h0000, 16'h0000, 16'h0000, 1, '{16'd160, 16'd100, 16'd0, 1'b0, 1'b0}},
         '{16'h1000, 16'h1000, 16'h1000, 1, '{16'd320, 16'd0, 16'sh4000, 1'b0, 1'b0}},
         '{16'hF000, 16'hF000, 16'hF000, 1, '{16'd0, 16'd200, 16'shC000, 1'b0, 1'b0}},
         '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
         '{16'h8000, 16'h8000, 16'h8000, 0, '0},
         '{16'h7FFF, 16'h8000, 16'h0001, 0, '0},
         '{16'h5555, 16'hAAAA, 16'hFFFF, 0, '0},
         '{16'hAAAA, 16'h5555, 16'h0000, 0, '0},
         '{16'h0800, 16'hF800, 16'h2000, 0, '0}
      };
      for (int i = 0; i < NUM_REGS; i++) mtx[i] = 32'h0;
      mtx[REG_ROW0_LO] = RST_DIAG_LO;
      mtx[REG_ROW1_LO] = RST_DIAG_HI;
      mtx[REG_ROW2_HI] = RST_DIAG_LO;
      mtx[REG_ROW3_HI] = RST_DIAG_HI;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows on the reset identity matrix
      foreach (dir_tab[i]) begin
         p = '{dir_tab[i].x, dir_tab[i].y, dir_tab[i].z};
         send_vertex(p, dir_tab[i].has_exp, dir_tab[i].exp_rsp);
      end
      wait_drain();

      // w row of zeros: every vertex has zero w
      write_reg(REG_ROW3_HI, 32'h0);
      p = '{16'h1234, 16'h8000, 16'h7FFF};
      send_vertex(p, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1, 1'b0});
      // tiny w forces saturation on all three outputs
      wait_drain();
      write_reg(REG_ROW3_HI, 32'h0001_0000);
      write_reg(REG_ROW0_LO, 32'h0000_7FFF);
      p = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_vertex(p, 1'b0, '0);
      wait_drain();

      // Matrix extremes, then random matrices across the idling mixes
      for (int ph = 0; ph < 12; ph++) begin
         load_matrix(ph);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         if (ph == 5) begin
            // long receiver hold while vertices keep coming
            hold_rsp = 1'b1;
            fork
               begin
                  repeat (200) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
            random_vertices(60);
         end
         random_vertices(RAND_ITEMS / 12);
         wait_drain();
      end

      if (fail_cnt == 0)
         $display("vertex_transform_project test passed");
      else
         $display("vertex_transform_project test failed");
      $finish;
   end

endmodule
